>>> src/rnsc_pkg.sv
`timescale 1ns / 1ps

package rnsc_pkg;

  localparam int unsigned TotalW   = 14;
  localparam int unsigned AddW     = 11;
  localparam int unsigned StepIdxW = 4;
  localparam int unsigned OutLimit = 21;
  localparam int unsigned CntW     = 5;

  localparam logic [TotalW-1:0] MAX_TOTAL = 14'd9999;

  // Pending symbol codes
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_I    = 2'd1;
  localparam logic [1:0] PEND_X    = 2'd2;
  localparam logic [1:0] PEND_C    = 2'd3;

  // ASCII codes of the Roman letters
  localparam logic [7:0] CHAR_NONE = 8'h00;
  localparam logic [7:0] CHAR_I    = 8'h49;
  localparam logic [7:0] CHAR_V    = 8'h56;
  localparam logic [7:0] CHAR_X    = 8'h58;
  localparam logic [7:0] CHAR_L    = 8'h4C;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_M    = 8'h4D;

  typedef enum logic {
    ST_ACCEPT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;       // accept the input item this cycle
    logic emit_step;  // run one step of the greedy emission
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a new item
    logic step_last;  // the current step loads the final item of the total
  } status_t;

  function automatic logic [TotalW-1:0] step_value(input logic [StepIdxW-1:0] idx);
    logic [TotalW-1:0] v;
    unique case (idx)
      4'd0:    v = 14'd1000;
      4'd1:    v = 14'd900;
      4'd2:    v = 14'd500;
      4'd3:    v = 14'd400;
      4'd4:    v = 14'd100;
      4'd5:    v = 14'd90;
      4'd6:    v = 14'd50;
      4'd7:    v = 14'd40;
      4'd8:    v = 14'd10;
      4'd9:    v = 14'd9;
      4'd10:   v = 14'd5;
      4'd11:   v = 14'd4;
      default: v = 14'd1;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] step_first(input logic [StepIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = CHAR_M;
      4'd1:    c = CHAR_C;
      4'd2:    c = CHAR_D;
      4'd3:    c = CHAR_C;
      4'd4:    c = CHAR_C;
      4'd5:    c = CHAR_X;
      4'd6:    c = CHAR_L;
      4'd7:    c = CHAR_X;
      4'd8:    c = CHAR_X;
      4'd9:    c = CHAR_I;
      4'd10:   c = CHAR_V;
      4'd11:   c = CHAR_I;
      default: c = CHAR_I;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] step_second(input logic [StepIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd1:    c = CHAR_M;
      4'd3:    c = CHAR_D;
      4'd5:    c = CHAR_C;
      4'd7:    c = CHAR_L;
      4'd9:    c = CHAR_X;
      4'd11:   c = CHAR_V;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

  // Subtractive steps sit at odd indexes up to 11
  function automatic logic step_two(input logic [StepIdxW-1:0] idx);
    return idx[0] && (idx <= 4'd11);
  endfunction

endpackage

>>> src/rnsc_ctrl.sv
`timescale 1ns / 1ps

module rnsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tlast_i,
  output logic              s_tready_o,
  input  rnsc_pkg::status_t status_i,
  output rnsc_pkg::cmd_t    cmd_o
);

  rnsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rnsc_pkg::ST_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    s_tready_o     = 1'b0;
    cmd_o.take     = 1'b0;
    cmd_o.emit_step = 1'b0;
    unique case (state_q)
      rnsc_pkg::ST_ACCEPT: begin
        s_tready_o = 1'b1;
        cmd_o.take = s_tvalid_i;
        if (s_tvalid_i && s_tlast_i) begin
          state_d = rnsc_pkg::ST_EMIT;
        end
      end
      rnsc_pkg::ST_EMIT: begin
        // step only when the output register has room
        cmd_o.emit_step = status_i.out_free;
        if (status_i.out_free && status_i.step_last) begin
          state_d = rnsc_pkg::ST_ACCEPT;
        end
      end
      default: state_d = rnsc_pkg::ST_ACCEPT;
    endcase
  end

endmodule

>>> src/rnsc_datapath.sv
`timescale 1ns / 1ps

module rnsc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rnsc_pkg::cmd_t    cmd_i,
  output rnsc_pkg::status_t status_o,
  input  logic [7:0]        char_code_i,
  input  logic              char_valid_i,
  input  logic              numeral_end_i,
  input  logic              stream_end_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [7:0]        out_char_o,
  output logic              out_empty_o,
  output logic              out_last_o
);

  logic [1:0]                     pend_q;
  logic [rnsc_pkg::TotalW-1:0]    total_q;
  logic [rnsc_pkg::TotalW-1:0]    rem_q;
  logic [rnsc_pkg::StepIdxW-1:0]  idx_q;
  logic                           phase_q;
  logic [rnsc_pkg::CntW-1:0]      cnt_q;
  logic                           m_valid_q;
  logic [7:0]                     m_char_q;
  logic                           m_empty_q;
  logic                           m_last_q;

  // Character decode
  logic [rnsc_pkg::AddW-1:0] char_val;
  logic [1:0]                char_pend;
  logic [rnsc_pkg::AddW-1:0] pend_val;
  logic [rnsc_pkg::AddW-1:0] pair_val;
  logic                      pair_hit;

  always_comb begin
    char_val  = '0;
    char_pend = rnsc_pkg::PEND_NONE;
    unique case (char_code_i)
      rnsc_pkg::CHAR_I: char_pend = rnsc_pkg::PEND_I;
      rnsc_pkg::CHAR_X: char_pend = rnsc_pkg::PEND_X;
      rnsc_pkg::CHAR_C: char_pend = rnsc_pkg::PEND_C;
      rnsc_pkg::CHAR_V: char_val  = 11'd5;
      rnsc_pkg::CHAR_L: char_val  = 11'd50;
      rnsc_pkg::CHAR_D: char_val  = 11'd500;
      rnsc_pkg::CHAR_M: char_val  = 11'd1000;
      default: ;
    endcase
  end

  always_comb begin
    pend_val = '0;
    pair_val = '0;
    pair_hit = 1'b0;
    unique case (pend_q)
      rnsc_pkg::PEND_I: begin
        pend_val = 11'd1;
        if (char_code_i == rnsc_pkg::CHAR_X) begin
          pair_hit = 1'b1;
          pair_val = 11'd9;
        end else if (char_code_i == rnsc_pkg::CHAR_V) begin
          pair_hit = 1'b1;
          pair_val = 11'd4;
        end
      end
      rnsc_pkg::PEND_X: begin
        pend_val = 11'd10;
        if (char_code_i == rnsc_pkg::CHAR_L) begin
          pair_hit = 1'b1;
          pair_val = 11'd40;
        end else if (char_code_i == rnsc_pkg::CHAR_C) begin
          pair_hit = 1'b1;
          pair_val = 11'd90;
        end
      end
      rnsc_pkg::PEND_C: begin
        pend_val = 11'd100;
        if (char_code_i == rnsc_pkg::CHAR_D) begin
          pair_hit = 1'b1;
          pair_val = 11'd400;
        end else if (char_code_i == rnsc_pkg::CHAR_M) begin
          pair_hit = 1'b1;
          pair_val = 11'd900;
        end
      end
      default: ;
    endcase
  end

  // Sum of everything one item adds; clamping once equals clamping each add
  logic [rnsc_pkg::AddW-1:0]   add_take;
  logic [rnsc_pkg::AddW-1:0]   add_end;
  logic [1:0]                  pend_mid;
  logic [1:0]                  pend_new;
  logic [rnsc_pkg::TotalW:0]   sum;
  logic [rnsc_pkg::TotalW-1:0] total_sat;

  always_comb begin
    add_take = '0;
    pend_mid = pend_q;
    if (char_valid_i) begin
      if (pair_hit) begin
        add_take = pair_val;
        pend_mid = rnsc_pkg::PEND_NONE;
      end else begin
        add_take = pend_val + char_val;
        pend_mid = char_pend;
      end
    end
    add_end  = '0;
    pend_new = pend_mid;
    if (numeral_end_i || stream_end_i) begin
      pend_new = rnsc_pkg::PEND_NONE;
      unique case (pend_mid)
        rnsc_pkg::PEND_I: add_end = 11'd1;
        rnsc_pkg::PEND_X: add_end = 11'd10;
        rnsc_pkg::PEND_C: add_end = 11'd100;
        default:          add_end = '0;
      endcase
    end
    sum = {1'b0, total_q} + 15'(add_take) + 15'(add_end);
    total_sat = (sum > {1'b0, rnsc_pkg::MAX_TOTAL}) ? rnsc_pkg::MAX_TOTAL
                                                     : sum[rnsc_pkg::TotalW-1:0];
  end

  // Greedy emission step
  logic [rnsc_pkg::TotalW-1:0] step_v;
  logic [rnsc_pkg::TotalW-1:0] rem_next;
  logic                        zero_total;
  logic                        hit;
  logic                        two;
  logic                        load;
  logic                        finishing;
  logic [7:0]                  step_char;

  always_comb begin
    step_v     = rnsc_pkg::step_value(idx_q);
    two        = rnsc_pkg::step_two(idx_q);
    zero_total = (rem_q == '0);
    hit        = (rem_q >= step_v);
    load       = zero_total || hit;
    rem_next   = rem_q - step_v;
    if (zero_total) begin
      step_char = rnsc_pkg::CHAR_NONE;
    end else if (phase_q) begin
      step_char = rnsc_pkg::step_second(idx_q);
    end else begin
      step_char = rnsc_pkg::step_first(idx_q);
    end
    finishing = zero_total
             || (hit && (!two || phase_q) && (rem_next == '0))
             || (hit && (cnt_q == rnsc_pkg::CntW'(rnsc_pkg::OutLimit - 1)));
  end

  assign status_o.out_free  = !m_valid_q || m_ready_i;
  assign status_o.step_last = load && finishing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= rnsc_pkg::PEND_NONE;
      total_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        if (stream_end_i) begin
          total_q <= '0;
          pend_q  <= rnsc_pkg::PEND_NONE;
        end else begin
          total_q <= total_sat;
          pend_q  <= pend_new;
        end
      end
      if (cmd_i.emit_step && load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && stream_end_i) begin
      rem_q   <= total_sat;
      idx_q   <= '0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else if (cmd_i.emit_step) begin
      if (load) begin
        m_char_q  <= step_char;
        m_empty_q <= zero_total;
        m_last_q  <= finishing;
        cnt_q     <= cnt_q + 1'b1;
        // first letter of a pair: hold the value until the second goes out
        if (two && !phase_q && !zero_total) begin
          phase_q <= 1'b1;
        end else begin
          phase_q <= 1'b0;
          rem_q   <= rem_next;
        end
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign m_valid_o   = m_valid_q;
  assign out_char_o  = m_char_q;
  assign out_empty_o = m_empty_q;
  assign out_last_o  = m_last_q;

endmodule

>>> src/roman_numeral_sum_converter.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata                  tuser                          tlast
// s_axis    in   [7:0] char_code        [0] char_valid [1] numeral_end stream_end
// m_axis    out  [7:0] out_char         [0] out_empty                  out_last
//
// Character items are taken back to back.
// A stream_end item starts emission: s_axis_tready_o drops until the last
// character is loaded. Each emission step loads one letter or skips one greedy
// weight: at most 21 letters plus 12 skips.
// A stalled m_axis holds its item; the controller steps only into a free slot.
// Reset clears the running total and pending symbol at once; no clearing pass.

module roman_numeral_sum_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic [1:0] s_axis_tuser_i,   // [0] char_valid, [1] numeral_end
  input  logic       s_axis_tlast_i,   // stream_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tuser_o,   // [0] out_empty
  output logic       m_axis_tlast_o    // out_last
);

  rnsc_pkg::cmd_t    cmd;
  rnsc_pkg::status_t status;

  rnsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rnsc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .char_code_i   (s_axis_tdata_i),
    .char_valid_i  (s_axis_tuser_i[0]),
    .numeral_end_i (s_axis_tuser_i[1]),
    .stream_end_i  (s_axis_tlast_i),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .out_char_o    (m_axis_tdata_o),
    .out_empty_o   (m_axis_tuser_o),
    .out_last_o    (m_axis_tlast_o)
  );

endmodule

>>> src/rnsc_checker.sv
`timescale 1ns / 1ps

module rnsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // Stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // Zero total is a single item
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("empty item without last");

  a_empty_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'h00)
    else $error("empty item carries a character");

  // Input closes while the total goes out
  a_stream_end_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input open right after stream end");

endmodule

bind roman_numeral_sum_converter rnsc_checker u_rnsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_empty;
    logic       is_last;
  } roman_out_t;

  // Greedy spelling table, largest weight first
  localparam int unsigned RomanWeight [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9,
                                               5, 4, 1};
  localparam logic [7:0] RomanHead [13] = '{
    rnsc_pkg::CHAR_M, rnsc_pkg::CHAR_C, rnsc_pkg::CHAR_D, rnsc_pkg::CHAR_C,
    rnsc_pkg::CHAR_C, rnsc_pkg::CHAR_X, rnsc_pkg::CHAR_L, rnsc_pkg::CHAR_X,
    rnsc_pkg::CHAR_X, rnsc_pkg::CHAR_I, rnsc_pkg::CHAR_V, rnsc_pkg::CHAR_I,
    rnsc_pkg::CHAR_I};
  localparam logic [7:0] RomanTail [13] = '{
    rnsc_pkg::CHAR_NONE, rnsc_pkg::CHAR_M, rnsc_pkg::CHAR_NONE, rnsc_pkg::CHAR_D,
    rnsc_pkg::CHAR_NONE, rnsc_pkg::CHAR_C, rnsc_pkg::CHAR_NONE, rnsc_pkg::CHAR_L,
    rnsc_pkg::CHAR_NONE, rnsc_pkg::CHAR_X, rnsc_pkg::CHAR_NONE, rnsc_pkg::CHAR_V,
    rnsc_pkg::CHAR_NONE};
  localparam int unsigned ItemTarget = 370;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_tdata = 8'h00;
  logic [1:0] s_tuser = 2'b00;  // [0] char_valid, [1] numeral_end
  logic       s_tlast = 1'b0;   // stream_end
  logic       m_axis_tvalid_o;
  logic       m_tready = 1'b0;
  logic [7:0] m_axis_tdata_o;   // [7:0] out_char
  logic       m_axis_tuser_o;   // [0] out_empty
  logic       m_axis_tlast_o;   // out_last

  // Predictor state
  logic [1:0]                  pend_sym = rnsc_pkg::PEND_NONE;
  logic [rnsc_pkg::TotalW-1:0] sum_total = '0;
  logic [7:0]                  spelled[$];
  roman_out_t                  exp_letters[$];

  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int unsigned rx_wait = 0;
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned totals_sent = 0;
  int unsigned totals_saturated = 0;
  int unsigned totals_empty = 0;
  int unsigned letters_checked = 0;

  roman_numeral_sum_converter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout: %0d letters still outstanding", exp_letters.size());
    $display("simulation failed");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void accumulate(input int unsigned v);
    int unsigned t;
    t = int'(sum_total) + v;
    if (t > int'(rnsc_pkg::MAX_TOTAL)) t = int'(rnsc_pkg::MAX_TOTAL);
    sum_total = rnsc_pkg::TotalW'(t);
  endfunction

  function automatic void flush_pending();
    case (pend_sym)
      rnsc_pkg::PEND_I: accumulate(1);
      rnsc_pkg::PEND_X: accumulate(10);
      rnsc_pkg::PEND_C: accumulate(100);
      default: ;
    endcase
    pend_sym = rnsc_pkg::PEND_NONE;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    if (pend_sym == rnsc_pkg::PEND_I && (c == rnsc_pkg::CHAR_X || c == rnsc_pkg::CHAR_V)) begin
      accumulate((c == rnsc_pkg::CHAR_X) ? 9 : 4);
      pend_sym = rnsc_pkg::PEND_NONE;
    end else if (pend_sym == rnsc_pkg::PEND_X &&
                 (c == rnsc_pkg::CHAR_L || c == rnsc_pkg::CHAR_C)) begin
      accumulate((c == rnsc_pkg::CHAR_L) ? 40 : 90);
      pend_sym = rnsc_pkg::PEND_NONE;
    end else if (pend_sym == rnsc_pkg::PEND_C &&
                 (c == rnsc_pkg::CHAR_D || c == rnsc_pkg::CHAR_M)) begin
      accumulate((c == rnsc_pkg::CHAR_D) ? 400 : 900);
      pend_sym = rnsc_pkg::PEND_NONE;
    end else begin
      // anything else flushes first; unknown codes add nothing
      flush_pending();
      case (c)
        rnsc_pkg::CHAR_I: pend_sym = rnsc_pkg::PEND_I;
        rnsc_pkg::CHAR_X: pend_sym = rnsc_pkg::PEND_X;
        rnsc_pkg::CHAR_C: pend_sym = rnsc_pkg::PEND_C;
        rnsc_pkg::CHAR_V: accumulate(5);
        rnsc_pkg::CHAR_L: accumulate(50);
        rnsc_pkg::CHAR_D: accumulate(500);
        rnsc_pkg::CHAR_M: accumulate(1000);
        default: ;
      endcase
    end
  endfunction

  // Greedy letters of n into spelled, cut off at the output limit
  function automatic void spell(input int unsigned n);
    int unsigned idx;
    idx = 0;
    spelled.delete();
    while (n != 0 && spelled.size() < rnsc_pkg::OutLimit && idx < 13) begin
      if (n >= RomanWeight[idx]) begin
        spelled.push_back(RomanHead[idx]);
        if (RomanTail[idx] != rnsc_pkg::CHAR_NONE && spelled.size() < rnsc_pkg::OutLimit)
          spelled.push_back(RomanTail[idx]);
        n -= RomanWeight[idx];
      end else begin
        idx++;
      end
    end
  endfunction

  function automatic void predict_item(input logic [7:0] code, input logic valid,
                                       input logic nend, input logic fin);
    roman_out_t r;
    if (valid) take_char(code);
    if (nend || fin) flush_pending();
    if (fin) begin
      totals_sent++;
      if (sum_total == rnsc_pkg::MAX_TOTAL) totals_saturated++;
      if (sum_total == '0) begin
        totals_empty++;
        r = '{ch: rnsc_pkg::CHAR_NONE, is_empty: 1'b1, is_last: 1'b1};
        exp_letters.push_back(r);
      end else begin
        spell(int'(sum_total));
        foreach (spelled[i]) begin
          r = '{ch: spelled[i], is_empty: 1'b0, is_last: (i == spelled.size() - 1)};
          exp_letters.push_back(r);
        end
      end
      sum_total = '0;
      pend_sym = rnsc_pkg::PEND_NONE;
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic [7:0] code, input logic valid,
                           input logic nend, input logic fin);
    int unsigned gap;
    logic rdy;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tuser  <= {nend, valid};
    s_tlast  <= fin;
    // sample ready mid-cycle, the handshake lands on the following edge
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    predict_item(code, valid, nend, fin);
    items_sent++;
  endtask

  // Hold the sender until every expected letter is out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (exp_letters.size() != 0);
  endtask

  task automatic send_numeral(input int unsigned lo, input int unsigned hi);
    logic [7:0] chars[$];
    int unsigned ending;
    spell($urandom_range(lo, hi));
    chars = spelled;
    ending = $urandom_range(0, 3);
    foreach (chars[i])
      send_item(chars[i], 1'b1, (i == chars.size() - 1) && ending < 2, 1'b0);
    if (ending == 2) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
  endtask

  task automatic send_stream(input int unsigned numerals, input int unsigned hi);
    int unsigned kind;
    for (int unsigned k = 0; k < numerals; k++) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        send_numeral(1, hi);
      end else if (kind < 17) begin
        // loose letters, often not a legal numeral
        repeat ($urandom_range(1, 6))
          send_item(RomanHead[$urandom_range(0, 12)], 1'b1, $urandom_range(0, 3) == 0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 4) == 0, 1'b0);
      end
    end
    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'b1);
    if ($urandom_range(0, 3) == 0) drain();
  endtask

  // Receiver: random stalls, held for the chosen length
  always @(posedge clk_i) begin
    if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
    end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      rx_wait  <= idle_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Sampled mid-cycle: these values hold through the next rising edge
  always @(negedge clk_i) begin
    roman_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (exp_letters.size() == 0) begin
        report_mismatch($sformatf("unexpected item char=%h empty=%b last=%b",
                                  m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o));
      end else begin
        want = exp_letters.pop_front();
        letters_checked++;
        if (m_axis_tdata_o !== want.ch)
          report_mismatch($sformatf("out_char %h, want %h", m_axis_tdata_o, want.ch));
        if (m_axis_tuser_o !== want.is_empty)
          report_mismatch($sformatf("out_empty %b, want %b", m_axis_tuser_o, want.is_empty));
        if (m_axis_tlast_o !== want.is_last)
          report_mismatch($sformatf("out_last %b, want %b", m_axis_tlast_o, want.is_last));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_each_letter();
    logic [7:0] word[7];
    word = '{rnsc_pkg::CHAR_M, rnsc_pkg::CHAR_D, rnsc_pkg::CHAR_C, rnsc_pkg::CHAR_L,
             rnsc_pkg::CHAR_X, rnsc_pkg::CHAR_V, rnsc_pkg::CHAR_I};
    foreach (word[i]) send_item(word[i], 1'b1, 1'b0, i == 6);
  endtask

  task automatic test_subtractive_pairs();
    logic [7:0] pairs[12];
    pairs = '{rnsc_pkg::CHAR_C, rnsc_pkg::CHAR_M, rnsc_pkg::CHAR_C, rnsc_pkg::CHAR_D,
              rnsc_pkg::CHAR_X, rnsc_pkg::CHAR_C, rnsc_pkg::CHAR_X, rnsc_pkg::CHAR_L,
              rnsc_pkg::CHAR_I, rnsc_pkg::CHAR_X, rnsc_pkg::CHAR_I, rnsc_pkg::CHAR_V};
    foreach (pairs[i]) send_item(pairs[i], 1'b1, i % 2 == 1, i == 11);
  endtask

  task automatic test_unknown_chars();
    send_item(rnsc_pkg::CHAR_X, 1'b1, 1'b0, 1'b0);
    send_item(8'h78, 1'b1, 1'b0, 1'b0);    // lower-case x flushes the pending X
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(rnsc_pkg::CHAR_I, 1'b1, 1'b0, 1'b0);
    send_item(rnsc_pkg::CHAR_V, 1'b0, 1'b1, 1'b0);   // not a character, just ends the numeral
    send_item(8'h00, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_zero_total();
    send_item(rnsc_pkg::CHAR_M, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_saturation();
    repeat (2) begin
      repeat (4) send_numeral(2500, 3999);
      send_item(rnsc_pkg::CHAR_NONE, 1'b0, 1'b0, 1'b1);
    end
    drain();
  endtask

  task automatic test_random_streams();
    while (items_sent < ItemTarget) begin
      tx_gaps_on   = $urandom_range(0, 2) != 0;
      rx_stalls_on = $urandom_range(0, 2) != 0;
      send_stream($urandom_range(1, 4), ($urandom_range(0, 3) == 0) ? 3999 : 60);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_letter();
    test_subtractive_pairs();
    test_unknown_chars();
    test_zero_total();
    test_saturation();
    test_random_streams();

    drain();
    repeat (40) @(posedge clk_i);
    $display("%0d items sent, %0d totals emitted (%0d saturated, %0d empty)",
             items_sent, totals_sent, totals_saturated, totals_empty);
    $display("%0d output letters checked, %0d mismatches", letters_checked, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/rnsc_pkg.sv
src/rnsc_ctrl.sv
src/rnsc_datapath.sv
src/roman_numeral_sum_converter.sv
src/rnsc_checker.sv
tb/testbench.sv
